>>> design/ifb_pkg.sv
// ifb_pkg: shared types and constants of the island falloff blend core
// no dependencies
package ifb_pkg;

   localparam int ELEV_W     = 18;
   localparam int COORD_W    = 12;
   localparam int CFG_DIM_W  = 13;
   localparam int CFG_MIX_W  = 17;
   localparam int CSR_DATA_W = 17;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_MAP_WIDTH     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAP_HEIGHT    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIX_AMOUNT    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_FALLOFF_SHAPE = 2'd3;

   localparam logic SHAPE_SQUARE = 1'b0;
   localparam logic SHAPE_RADIAL = 1'b1;

   // sideband that travels with each word down the pipeline
   typedef struct packed {
      logic              valid;
      logic              pass;
      logic [ELEV_W-1:0] elev;
   } side_type;

endpackage

>>> design/ifb_div.sv
// ifb_div: pipelined normalization of one coordinate, restoring divide one bit a stage
// output is |2*pos/(dim-1) - 1| clamped to 1.0; depends on ifb_pkg
module ifb_div #(
   parameter int MAX_DIM   = 4096,
   parameter int FRAC_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  en,
   input  logic [ifb_pkg::COORD_W-1:0]           pos,
   input  logic [ifb_pkg::CFG_DIM_W-1:0]         dim,
   output logic [FRAC_BITS:0]                    ax
);
   import ifb_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int QB = F + 2;
   localparam int DW = (MAX_DIM > 2) ? $clog2(MAX_DIM) : 1;
   localparam int NW = ((COORD_W + 1 + F > DW) ? COORD_W + 1 + F : DW) + 1;
   localparam int CW = NW + DW + QB;
   localparam logic [QB-1:0] ONE_Q = QB'(1) << F;
   localparam logic [QB-1:0] TWO_Q = QB'(1) << (F + 1);

   logic [DW-1:0] rem_ff  [QB+1];
   logic [QB-1:0] q_ff    [QB+1];
   logic [QB-1:0] nl_ff   [QB+1];
   logic [DW-1:0] den_ff  [QB+1];
   logic          sat_ff  [QB+1];
   logic          zero_ff [QB+1];
   logic [DW-1:0] rem_in  [QB+1];
   logic [QB-1:0] q_in    [QB+1];
   logic [F:0]    ax_ff;
   logic [F:0]    ax_in;

   logic [31:0]   dim32;
   logic [DW-1:0] den0;
   logic [NW-1:0] num0;

   always_comb begin
      dim32 = 32'(dim);
      if (dim32 > 32'(MAX_DIM)) begin
         dim32 = 32'(MAX_DIM);
      end
      den0 = DW'(dim32 - 32'd1);
      num0 = (NW'(pos) << (F + 1)) + NW'(den0 >> 1);
   end

   always_comb begin
      rem_in[0] = DW'(num0 >> QB);
      q_in[0]   = '0;
      for (int k = 1; k <= QB; k++) begin
         logic [DW:0] t;
         t = {rem_ff[k-1], nl_ff[k-1][QB-1]};
         if (t >= {1'b0, den_ff[k-1]}) begin
            rem_in[k] = DW'(t - {1'b0, den_ff[k-1]});
            q_in[k]   = {q_ff[k-1][QB-2:0], 1'b1};
         end else begin
            rem_in[k] = t[DW-1:0];
            q_in[k]   = {q_ff[k-1][QB-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff[0]  <= rem_in[0];
         q_ff[0]    <= q_in[0];
         nl_ff[0]   <= num0[QB-1:0];
         den_ff[0]  <= den0;
         zero_ff[0] <= (dim32 <= 32'd1);
         sat_ff[0]  <= (CW'(num0) >= (CW'(den0) << QB));
         for (int k = 1; k <= QB; k++) begin
            rem_ff[k]  <= rem_in[k];
            q_ff[k]    <= q_in[k];
            nl_ff[k]   <= {nl_ff[k-1][QB-2:0], 1'b0};
            den_ff[k]  <= den_ff[k-1];
            zero_ff[k] <= zero_ff[k-1];
            sat_ff[k]  <= sat_ff[k-1];
         end
         ax_ff <= ax_in;
      end
   end

   always_comb begin
      if (zero_ff[QB]) begin
         ax_in = '0;
      end else if (sat_ff[QB] || (q_ff[QB] > TWO_Q)) begin
         ax_in = (F+1)'(ONE_Q);
      end else if (q_ff[QB] >= ONE_Q) begin
         ax_in = (F+1)'(q_ff[QB] - ONE_Q);
      end else begin
         ax_in = (F+1)'(ONE_Q - q_ff[QB]);
      end
   end

   assign ax = ax_ff;

endmodule

>>> design/ifb_sqrt.sv
// ifb_sqrt: pipelined integer square root rounded to nearest, one result bit a stage
// depends on ifb_pkg
module ifb_sqrt #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic [2*FRAC_BITS+1:0] s,
   output logic [FRAC_BITS:0]     root
);
   import ifb_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int SW = 2 * F + 2;

   logic [SW-1:0] s_ff  [F+1];
   logic [SW-1:0] r_ff  [F+1];
   logic [SW-1:0] s_in  [F+1];
   logic [SW-1:0] r_in  [F+1];
   logic [F:0]    root_ff;

   always_comb begin
      for (int k = 0; k <= F; k++) begin
         logic [SW-1:0] sp;
         logic [SW-1:0] rp;
         logic [SW-1:0] bitv;
         logic [SW:0]   sum;
         sp   = (k == 0) ? s : s_ff[(k == 0) ? 0 : k - 1];
         rp   = (k == 0) ? '0 : r_ff[(k == 0) ? 0 : k - 1];
         bitv = SW'(1) << (2 * (F - k));
         sum  = (SW+1)'(rp) + (SW+1)'(bitv);
         if ((SW+1)'(sp) >= sum) begin
            s_in[k] = SW'((SW+1)'(sp) - sum);
            r_in[k] = (rp >> 1) + bitv;
         end else begin
            s_in[k] = sp;
            r_in[k] = rp >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k <= F; k++) begin
            s_ff[k] <= s_in[k];
            r_ff[k] <= r_in[k];
         end
         // round up when the remainder exceeds the root
         root_ff <= (F+1)'(r_ff[F] + SW'(s_ff[F] > r_ff[F]));
      end
   end

   assign root = root_ff;

endmodule

>>> design/island_falloff_blend_core.sv
// island_falloff_blend_core: island falloff mask and elevation blend, top level
// depends on ifb_pkg, ifb_div, ifb_sqrt
//
//   channel  direction  ports                                   moves
//   req      in         req_valid/req_stall, column,row,elev    one sample word
//   rsp      out        rsp_valid/rsp_stall, elevation_out      one result word
//   csr      in         csr_write_en, csr_index, csr_data       register write
//
// one word accepted per cycle unless rsp stalls the pipeline; the datapath is built from
// the one-bit-a-stage divider (FRAC_BITS+4) and square root (FRAC_BITS+2) chains
// reset clears the valid bits and loads the register defaults
// a stall on rsp while rsp_valid is high freezes the whole pipeline; req_stall follows it directly
module island_falloff_blend_core #(
   parameter int MAX_DIM   = 4096,
   parameter int FRAC_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [ifb_pkg::COORD_W-1:0]         req_column,
   input  logic [ifb_pkg::COORD_W-1:0]         req_row,
   input  logic signed [ifb_pkg::ELEV_W-1:0]   req_elevation_in,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [ifb_pkg::ELEV_W-1:0]   rsp_elevation_out,
   input  logic                                csr_write_en,
   input  logic [ifb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ifb_pkg::CSR_DATA_W-1:0]      csr_data
);
   import ifb_pkg::*;

   localparam int F    = FRAC_BITS;
   localparam int FW   = F + 1;
   localparam int SW   = 2 * F + 2;
   localparam int QB   = F + 2;
   localparam int SQL  = F + 2;
   localparam int KD   = QB + 2;
   localparam int KM   = KD + 1;
   localparam int KN   = KM + 1;
   localparam int KT   = KN + SQL;
   localparam int KQ   = KT + 1;
   localparam int KR   = KQ + 1;
   localparam int KS   = KR + 1;
   localparam int DFW  = ((F + 2 > ELEV_W) ? F + 2 : ELEV_W) + 1;
   localparam int PW   = DFW + F + 2;
   localparam logic [FW-1:0] ONE  = FW'(1) << F;
   localparam logic [SW-1:0] HALF = SW'(1) << (F - 1);

   logic [CFG_DIM_W-1:0] width_ff;
   logic [CFG_DIM_W-1:0] height_ff;
   logic [CFG_MIX_W-1:0] mix_ff;
   logic                 shape_ff;

   logic                 en;
   side_type             side_ff [KS+1];
   logic [COORD_W-1:0]   col_ff;
   logic [COORD_W-1:0]   row_ff;

   logic [FW-1:0]        ax;
   logic [FW-1:0]        ay;
   logic [SW-1:0]        ax2_ff;
   logic [SW-1:0]        ay2_ff;
   logic [FW-1:0]        a_ff;
   logic [FW-1:0]        b_ff;
   logic [SW-1:0]        s_ff;
   logic [FW-1:0]        dsq_ff [SQL];
   logic [FW-1:0]        root;

   logic [FW-1:0]        sx_in;
   logic [FW-1:0]        sy_in;
   logic [FW-1:0]        dsq_in;
   logic [SW-1:0]        ab;

   logic [FW-1:0]        d_sel;
   logic [FW-1:0]        t_val;
   logic signed [DFW-1:0] diff_ff;
   logic signed [DFW-1:0] diff_in;
   logic [FW-1:0]        mix_c;
   logic signed [PW-1:0] prod_ff;
   logic signed [PW-1:0] prod_in;
   logic [PW-1:0]        absprod;
   logic [PW-1:0]        mag;
   logic signed [PW-1:0] rr_ff;
   logic signed [PW-1:0] rr_in;
   logic signed [PW:0]   res;
   logic [FW-1:0]        res_c;

   logic                 rsp_valid_ff;
   logic [ELEV_W-1:0]    rsp_elev_ff;
   logic [ELEV_W-1:0]    rsp_elev_in;

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CFG_DIM_W'(1);
         height_ff <= CFG_DIM_W'(1);
         mix_ff    <= '0;
         shape_ff  <= SHAPE_RADIAL;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_MAP_WIDTH:     width_ff  <= csr_data[CFG_DIM_W-1:0];
            REG_MAP_HEIGHT:    height_ff <= csr_data[CFG_DIM_W-1:0];
            REG_MIX_AMOUNT:    mix_ff    <= csr_data[CFG_MIX_W-1:0];
            REG_FALLOFF_SHAPE: shape_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // sideband line, one slot per stage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= KS; k++) begin
            side_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         side_ff[0].valid <= req_valid;
         for (int k = 1; k <= KS; k++) begin
            side_ff[k].valid <= side_ff[k-1].valid;
         end
      end
      if (en) begin
         side_ff[0].pass <= (mix_ff == '0);
         side_ff[0].elev <= req_elevation_in;
         col_ff          <= req_column;
         row_ff          <= req_row;
         for (int k = 1; k <= KS; k++) begin
            side_ff[k].pass <= side_ff[k-1].pass;
            side_ff[k].elev <= side_ff[k-1].elev;
         end
      end
   end

   ifb_div #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_div_x (
      .clock (clock),
      .en    (en),
      .pos   (col_ff),
      .dim   (width_ff),
      .ax    (ax)
   );

   ifb_div #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_div_y (
      .clock (clock),
      .en    (en),
      .pos   (row_ff),
      .dim   (height_ff),
      .ax    (ay)
   );

   always_comb begin
      sx_in  = FW'((ax2_ff + HALF) >> F);
      sy_in  = FW'((ay2_ff + HALF) >> F);
      ab     = SW'(a_ff) * SW'(b_ff);
      dsq_in = ONE - FW'((ab + HALF) >> F);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax2_ff    <= SW'(ax) * SW'(ax);
         ay2_ff    <= SW'(ay) * SW'(ay);
         a_ff      <= ONE - sx_in;
         b_ff      <= ONE - sy_in;
         s_ff      <= ax2_ff + ay2_ff;
         dsq_ff[0] <= dsq_in;
         for (int k = 1; k < SQL; k++) begin
            dsq_ff[k] <= dsq_ff[k-1];
         end
      end
   end

   ifb_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
      .clock (clock),
      .en    (en),
      .s     (s_ff),
      .root  (root)
   );

   always_comb begin
      if (shape_ff == SHAPE_SQUARE) begin
         d_sel = dsq_ff[SQL-1];
      end else begin
         d_sel = (root > ONE) ? ONE : root;
      end
      t_val   = ONE - d_sel;
      diff_in = DFW'(t_val) - DFW'($signed(side_ff[KT].elev));
      mix_c   = (32'(mix_ff) > 32'(ONE)) ? ONE : FW'(mix_ff);
      prod_in = PW'(diff_ff) * PW'($signed({1'b0, mix_c}));
      absprod = prod_ff[PW-1] ? PW'(-prod_ff) : PW'(prod_ff);
      mag     = (absprod + PW'(HALF)) >> F;
      rr_in   = prod_ff[PW-1] ? -$signed(mag) : $signed(mag);
      res     = (PW+1)'(rr_ff) + (PW+1)'($signed(side_ff[KS].elev));
      if (res < 0) begin
         res_c = '0;
      end else if (res > $signed((PW+1)'(ONE))) begin
         res_c = ONE;
      end else begin
         res_c = FW'(res);
      end
      rsp_elev_in = side_ff[KS].pass ? side_ff[KS].elev : ELEV_W'(res_c);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= diff_in;
         prod_ff <= prod_in;
         rr_ff   <= rr_in;
         rsp_elev_ff <= rsp_elev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= side_ff[KS].valid;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_elevation_out = $signed(rsp_elev_ff);

endmodule

>>> sim/ifb_checker.sv
// ifb_checker: watches the sample and result channels of the falloff blend core,
// predicts every result word and compares it; depends on ifb_pkg
module ifb_checker (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic [ifb_pkg::COORD_W-1:0]       req_column,
   input  logic [ifb_pkg::COORD_W-1:0]       req_row,
   input  logic signed [ifb_pkg::ELEV_W-1:0] req_elevation_in,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic signed [ifb_pkg::ELEV_W-1:0] rsp_elevation_out,
   input  logic                              csr_write_en,
   input  logic [ifb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [ifb_pkg::CSR_DATA_W-1:0]    csr_data,
   output int                                error_count,
   output int                                pending_count,
   output int                                result_count
);
   import ifb_pkg::*;

   localparam longint ONE  = 64'd65536;
   localparam longint HALF = 64'd32768;

   logic [CFG_DIM_W-1:0] width_q, height_q;
   logic [CFG_MIX_W-1:0] mix_q;
   logic                 shape_q;
   logic [ELEV_W-1:0]    elev_expected[$];

   function automatic longint norm_pos(longint pos, longint dim);
      longint den, q, v;
      if (dim > 4096) dim = 4096;
      if (dim <= 1) return 0;
      den = dim - 1;
      q = ((2 * pos) * ONE + den / 2) / den;
      v = q - ONE;
      if (v > ONE) v = ONE;
      return v;
   endfunction

   function automatic longint round_sqrt(longint s);
      longint r, c;
      r = 0;
      for (int k = 17; k >= 0; k--) begin
         c = r + (longint'(1) << k);
         if (c * c <= s) r = c;
      end
      // nearest: remainder beyond r means round up
      if (s - r * r > r) r++;
      return r;
   endfunction

   function automatic logic [ELEV_W-1:0] blend_elevation(logic [COORD_W-1:0] col,
         logic [COORD_W-1:0] row, logic signed [ELEV_W-1:0] elev);
      longint e, mix, ax, ay, d, t, prod, mag, r, res, sx, sy, p;
      e = elev;
      mix = mix_q;
      if (mix > ONE) mix = ONE;
      if (mix == 0) return elev;
      ax = norm_pos(col, width_q);
      ay = norm_pos(row, height_q);
      if (ax < 0) ax = -ax;
      if (ay < 0) ay = -ay;
      if (shape_q == SHAPE_SQUARE) begin
         sx = (ax * ax + HALF) >>> 16;
         sy = (ay * ay + HALF) >>> 16;
         p = ((ONE - sx) * (ONE - sy) + HALF) >>> 16;
         d = ONE - p;
      end else begin
         d = round_sqrt(ax * ax + ay * ay);
      end
      if (d > ONE) d = ONE;
      if (d < 0) d = 0;
      t = ONE - d;
      prod = (t - e) * mix;
      mag = ((prod < 0 ? -prod : prod) + HALF) >>> 16;
      r = prod < 0 ? -mag : mag;
      res = e + r;
      if (res < 0) res = 0;
      if (res > ONE) res = ONE;
      return res[ELEV_W-1:0];
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         width_q <= CFG_DIM_W'(1);
         height_q <= CFG_DIM_W'(1);
         mix_q <= '0;
         shape_q <= SHAPE_RADIAL;
         error_count <= 0;
         result_count <= 0;
         elev_expected.delete();
      end else begin
         if (csr_write_en) begin
            case (csr_index)
               REG_MAP_WIDTH:     width_q <= csr_data[CFG_DIM_W-1:0];
               REG_MAP_HEIGHT:    height_q <= csr_data[CFG_DIM_W-1:0];
               REG_MIX_AMOUNT:    mix_q <= csr_data[CFG_MIX_W-1:0];
               REG_FALLOFF_SHAPE: shape_q <= csr_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall)
            elev_expected.push_back(blend_elevation(req_column, req_row, req_elevation_in));
         if (rsp_valid && !rsp_stall) begin
            result_count <= result_count + 1;
            if (elev_expected.size() == 0) begin
               $display("%0t: result word %h with nothing expected", $time, rsp_elevation_out);
               error_count <= error_count + 1;
            end else begin
               if (elev_expected[0] !== rsp_elevation_out) begin
                  $display("%0t: elevation_out expected %h actual %h", $time,
                           elev_expected[0], rsp_elevation_out);
                  error_count <= error_count + 1;
               end
               void'(elev_expected.pop_front());
            end
         end
      end
   end

   assign pending_count = elev_expected.size();
endmodule

>>> sim/tb.sv
// tb: stimulus and verdict for island_falloff_blend_core
// depends on ifb_pkg, the core and ifb_checker
module tb;
   import ifb_pkg::*;

   logic clock = 0, reset = 1;
   logic req_valid = 0, rsp_stall = 0, csr_write_en = 0;
   logic req_stall, rsp_valid;
   logic [COORD_W-1:0] req_column = 0, req_row = 0;
   logic signed [ELEV_W-1:0] req_elevation_in = 0, rsp_elevation_out;
   logic [CSR_IDX_W-1:0] csr_index = 0;
   logic [CSR_DATA_W-1:0] csr_data = 0;
   int error_count, pending_count, result_count;
   int send_idle_pct = 0, recv_idle_pct = 0, hold_off = 0;
   logic hold_req = 0, hold_seen = 0;
   int cycle_count = 0;
   int cur_w = 1, cur_h = 1;

   always #5 clock = ~clock;

   island_falloff_blend_core i_dut (.*);

   ifb_checker i_checker (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 400000) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // receiver stall, with a long hold-off when asked
   always @(posedge clock) begin
      if (hold_req != hold_seen) begin
         hold_seen <= hold_req;
         hold_off <= 300;
         rsp_stall <= 1'b1;
      end else if (hold_off > 0) begin
         rsp_stall <= 1'b1;
         hold_off <= hold_off - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, int value);
      @(posedge clock);
      csr_write_en <= 1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_write_en <= 0;
   endtask

   task automatic drain;
      req_valid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic set_map(int w, int h, int mix, int shape);
      drain();
      cur_w = w;
      cur_h = h;
      write_reg(REG_MAP_WIDTH, w);
      write_reg(REG_MAP_HEIGHT, h);
      write_reg(REG_MIX_AMOUNT, mix);
      write_reg(REG_FALLOFF_SHAPE, shape);
   endtask

   task automatic send_sample(int col, int row, int elev);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_column <= COORD_W'(col);
      req_row <= COORD_W'(row);
      req_elevation_in <= ELEV_W'(elev);
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   function automatic int rand_elev();
      case ($urandom_range(3))
         0: return $urandom_range(65536);
         1: return -131072 + $urandom_range(262143);
         2: return $urandom_range(1) ? 131071 : -131072;
         default: return $urandom_range(70000) - 2000;
      endcase
   endfunction

   function automatic int rand_pos(int dim);
      // mostly inside the map, sometimes beyond it
      if ($urandom_range(9) == 0 || dim <= 1) return $urandom_range(4095);
      return $urandom_range((dim > 4096 ? 4096 : dim) - 1);
   endfunction

   task automatic random_phase(int n);
      int dims[6] = '{1, 2, 3, 640, 4096, 8191};
      int mixes[5] = '{0, 1, 32768, 65536, 131071};
      for (int p = 0; p < n / 100; p++) begin
         set_map(($urandom_range(3) == 0) ? dims[$urandom_range(5)] : 1 + $urandom_range(4095),
                 ($urandom_range(3) == 0) ? dims[$urandom_range(5)] : 1 + $urandom_range(4095),
                 ($urandom_range(2) == 0) ? mixes[$urandom_range(4)] : $urandom_range(131071),
                 $urandom_range(1));
         for (int i = 0; i < 100; i++)
            send_sample(rand_pos(cur_w), rand_pos(cur_h), rand_elev());
      end
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      // reset defaults: mix zero passes words through
      send_sample(4095, 0, -131072);
      send_sample(0, 4095, 131071);
      set_map(4096, 4096, 65536, SHAPE_SQUARE);
      send_sample(0, 0, 0);
      send_sample(4095, 4095, 65536);
      send_sample(2048, 2047, -131072);
      send_sample(4095, 0, 131071);
      set_map(4096, 1, 131071, SHAPE_RADIAL);
      send_sample(2048, 4095, 40000);
      send_sample(0, 0, -5);
      send_sample(4095, 77, 131071);
      set_map(8191, 0, 32768, SHAPE_SQUARE);
      send_sample(4095, 3000, 12345);
      send_sample(100, 0, -131072);
      set_map(2, 3, 1, SHAPE_RADIAL);
      send_sample(1, 2, 65535);
      send_sample(4095, 4095, -1);
      send_sample(0, 1, 99999);
      set_map(5, 5, 0, SHAPE_SQUARE);
      send_sample(4, 4, -77777);
      send_sample(4095, 1234, 131071);

      send_idle_pct = 25; recv_idle_pct = 77;
      random_phase(500);
      // long receiver hold-off while the sender keeps offering words
      hold_req <= ~hold_req;
      for (int i = 0; i < 50; i++) send_sample(rand_pos(cur_w), rand_pos(cur_h), rand_elev());
      drain();
      send_idle_pct = 77; recv_idle_pct = 25;
      random_phase(500);
      send_idle_pct = 0; recv_idle_pct = 0;
      random_phase(500);

      drain();
      $display("covered %0d result words over square and radial falloff,", result_count);
      $display("mix zero to above one, dimensions one to beyond max, both idling mixes");
      if (error_count == 0) $display("Testbench completed without errors");
      else $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule

>>> island_falloff_blend_core.f
design/ifb_pkg.sv
design/ifb_div.sv
design/ifb_sqrt.sv
design/island_falloff_blend_core.sv
sim/ifb_checker.sv
sim/tb.sv
